[hdl/ldw_pkg.sv]
// shared types, constants and digit lookup for the lcd digit writer
`default_nettype none

package ldw_pkg;

  // number of digit positions kept
  localparam int unsigned DigitCount = 6;
  // widths fixed by the item fields
  localparam int unsigned NumW       = 31;
  localparam int unsigned CharW      = 8;
  localparam int unsigned PosW       = 3;
  // decimal digits needed for a 31-bit value
  localparam int unsigned BcdDigits  = 10;
  localparam int unsigned BcdW       = 4 * BcdDigits;
  localparam int unsigned StepW      = $clog2(NumW);
  localparam int unsigned LeadW      = $clog2(BcdDigits);
  // output bytes: four rows of three digit pairs
  localparam int unsigned RowCount   = 4;
  localparam int unsigned PairCount  = 3;
  localparam int unsigned ByteCount  = RowCount * PairCount;
  // slots addressable by the output packing
  localparam int unsigned SlotCount  = 8;

  localparam logic [CharW-1:0] AsciiZero = 8'd48;
  localparam logic [15:0] BlankPattern   = 16'h0000;

  typedef logic [15:0] pattern_t;
  typedef logic [DigitCount-1:0][15:0] pat_arr_t;
  typedef logic [ByteCount-1:0][7:0] bytes_t;

  localparam pattern_t DigitTable [10] = '{
    16'h1551, 16'h2080, 16'h1e11, 16'h1b11, 16'h0b50,
    16'h1b41, 16'h1f41, 16'h0111, 16'h1f51, 16'h0b51
  };

  // operation codes
  typedef enum logic {
    OP_CHAR   = 1'b0,
    OP_NUMBER = 1'b1
  } op_e;

  // one classified command between front and back
  typedef struct packed {
    op_e              op;
    pattern_t         pattern;
    logic [PosW-1:0]  position;
    logic [NumW-1:0]  number;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_APPLY,
    BK_EMIT
  } back_state_e;

  // segment pattern of one decimal digit
  function automatic pattern_t digit_pattern(input logic [3:0] d);
    pattern_t p;
    p = BlankPattern;
    if (d <= 4'd9) begin
      p = DigitTable[d];
    end
    return p;
  endfunction

  // segment pattern of an ascii code, blank unless '0'..'9'
  function automatic pattern_t char_pattern(input logic [CharW-1:0] c);
    logic [CharW-1:0] off;
    pattern_t p;
    off = c - AsciiZero;
    p = BlankPattern;
    if (c >= AsciiZero && c <= AsciiZero + 8'd9) begin
      p = DigitTable[off[3:0]];
    end
    return p;
  endfunction

endpackage

`default_nettype wire

[hdl/lcd_decimal_digit_writer_unit.sv]
// top level of the lcd decimal digit writer
//
// Keeps a 16-bit segment pattern for each of six digit positions and, after
// every item, presents the twelve lcd data-register bytes (row r holds nibble
// r of each digit, even digit low, odd digit high). A character item stores
// the pattern of an ascii digit, or blank, at one position; a number item is
// converted to decimal and shown left-aligned with trailing positions blank.
// Items go through a two-entry command queue into the back end, which takes a
// queued command in the cycle after its input transfer when it is idle. A
// character item then passes the apply and emit states; a number item first
// passes the 31-step shift-add-3 converter, one input bit per cycle. The back
// end takes no new item until it has emitted its result, and it waits to emit
// while an unpopped result is held. The result register lets the back end
// start the next item while the previous result waits to be popped.
`default_nettype none

module lcd_decimal_digit_writer_unit import ldw_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output      logic             full,
  input  wire logic             op_i,
  input  wire logic [CharW-1:0] char_code_i,
  input  wire logic [PosW-1:0]  position_i,
  input  wire logic [NumW-1:0]  number_i,
  output      logic             empty,
  input  wire logic             pop,
  output      logic [7:0]       row0_digits01_o,
  output      logic [7:0]       row0_digits23_o,
  output      logic [7:0]       row0_digits45_o,
  output      logic [7:0]       row1_digits01_o,
  output      logic [7:0]       row1_digits23_o,
  output      logic [7:0]       row1_digits45_o,
  output      logic [7:0]       row2_digits01_o,
  output      logic [7:0]       row2_digits23_o,
  output      logic [7:0]       row2_digits45_o,
  output      logic [7:0]       row3_digits01_o,
  output      logic [7:0]       row3_digits23_o,
  output      logic [7:0]       row3_digits45_o
);

  logic   cmd_valid;
  logic   cmd_ready;
  cmd_t   cmd;
  logic   out_valid;
  bytes_t out_bytes;

  // front end and command queue
  ldw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .char_code_i (char_code_i),
    .position_i  (position_i),
    .number_i    (number_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // back end
  ldw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid),
    .pop_i       (pop),
    .out_bytes_o (out_bytes)
  );

  // result ports
  assign empty           = !out_valid;
  assign row0_digits01_o = out_bytes[0];
  assign row0_digits23_o = out_bytes[1];
  assign row0_digits45_o = out_bytes[2];
  assign row1_digits01_o = out_bytes[3];
  assign row1_digits23_o = out_bytes[4];
  assign row1_digits45_o = out_bytes[5];
  assign row2_digits01_o = out_bytes[6];
  assign row2_digits23_o = out_bytes[7];
  assign row2_digits45_o = out_bytes[8];
  assign row3_digits01_o = out_bytes[9];
  assign row3_digits23_o = out_bytes[10];
  assign row3_digits45_o = out_bytes[11];

  // a full queue always offers a command to the back end
  a_full_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> cmd_valid)
    else $error("queue full without a pending command");

  // back end is busy right after taking a command
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("back end ready right after command transfer");

  // a new result only appears out of a busy back end
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(!cmd_ready))
    else $error("result appeared while back end was idle");

endmodule

`default_nettype wire

[hdl/ldw_front.sv]
// front end: takes items, looks up char patterns, holds a two-entry command queue
`default_nettype none

module ldw_front import ldw_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output      logic            full,
  input  wire logic            op_i,
  input  wire logic [CharW-1:0] char_code_i,
  input  wire logic [PosW-1:0] position_i,
  input  wire logic [NumW-1:0] number_i,
  output      logic            cmd_valid_o,
  input  wire logic            cmd_ready_i,
  output      cmd_t            cmd_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       in_xfer;
  logic       out_xfer;
  cmd_t       cmd_new;

  // classify the incoming item
  always_comb begin
    cmd_new.op       = op_e'(op_i);
    cmd_new.pattern  = char_pattern(char_code_i);
    cmd_new.position = position_i;
    cmd_new.number   = number_i;
  end

  assign full        = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign in_xfer     = push && !full;
  assign out_xfer    = cmd_valid_o && cmd_ready_i;

  // queue pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ in_xfer;
    rd_ptr_d = rd_ptr_q ^ out_xfer;
    count_d  = count_q;
    if (in_xfer && !out_xfer) begin
      count_d = count_q + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

[hdl/ldw_back.sv]
// back end: decimal conversion, digit pattern store and result register
`default_nettype none

module ldw_back import ldw_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cmd_valid_i,
  output      logic   cmd_ready_o,
  input  wire cmd_t   cmd_i,
  output      logic   out_valid_o,
  input  wire logic   pop_i,
  output      bytes_t out_bytes_o
);

  back_state_e        state_q, state_d;
  cmd_t               cmd_q;
  logic [BcdW-1:0]    bcd_q;
  logic [BcdW-1:0]    bcd_adj;
  logic [NumW-1:0]    shift_q;
  logic [StepW-1:0]   step_q;
  pat_arr_t           pat_q;
  pat_arr_t           pat_num;
  logic [LeadW-1:0]   lead;
  bytes_t             out_bytes_q;
  logic               out_valid_q;
  logic               take_cmd;
  logic               conv_step;
  logic               apply_cmd;
  logic               emit;

  // pack digit nibbles into lcd row bytes, missing positions read zero
  function automatic bytes_t pack_bytes(input pat_arr_t pat);
    logic [SlotCount-1:0][15:0] ext;
    bytes_t b;
    ext = '0;
    for (int j = 0; j < DigitCount; j++) begin
      ext[j] = pat[j];
    end
    for (int r = 0; r < RowCount; r++) begin
      for (int p = 0; p < PairCount; p++) begin
        b[r*PairCount + p] = {ext[2*p+1][4*r +: 4], ext[2*p][4*r +: 4]};
      end
    end
    return b;
  endfunction

  // sequencer
  always_comb begin
    state_d     = state_q;
    cmd_ready_o = 1'b0;
    take_cmd    = 1'b0;
    conv_step   = 1'b0;
    apply_cmd   = 1'b0;
    emit        = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          take_cmd = 1'b1;
          state_d  = (cmd_i.op == OP_NUMBER) ? BK_CONV : BK_APPLY;
        end
      end
      BK_CONV: begin
        conv_step = 1'b1;
        if (step_q == '0) begin
          state_d = BK_APPLY;
        end
      end
      BK_APPLY: begin
        apply_cmd = 1'b1;
        state_d   = BK_EMIT;
      end
      BK_EMIT: begin
        if (!out_valid_q || pop_i) begin
          emit    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // add three to every bcd digit of five or more
  always_comb begin
    for (int k = 0; k < BcdDigits; k++) begin
      bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
                                                     : bcd_q[4*k +: 4];
    end
  end

  // shift-add-3 conversion, one input bit per cycle
  always_ff @(posedge clk_i) begin
    if (take_cmd) begin
      cmd_q   <= cmd_i;
      bcd_q   <= '0;
      shift_q <= cmd_i.number;
      step_q  <= StepW'(NumW - 1);
    end else if (conv_step) begin
      bcd_q   <= {bcd_adj[BcdW-2:0], shift_q[NumW-1]};
      shift_q <= {shift_q[NumW-2:0], 1'b0};
      step_q  <= step_q - 1'b1;
    end
  end

  // most significant nonzero digit, zero shows one digit
  always_comb begin
    lead = '0;
    for (int k = 1; k < BcdDigits; k++) begin
      if (bcd_q[4*k +: 4] != 4'd0) begin
        lead = LeadW'(k);
      end
    end
  end

  // left-aligned digit placement, blank past the last digit
  always_comb begin
    logic [LeadW-1:0] idx;
    for (int j = 0; j < DigitCount; j++) begin
      idx = lead - LeadW'(j);
      if (j <= int'(lead)) begin
        pat_num[j] = digit_pattern(bcd_q[{idx, 2'b00} +: 4]);
      end else begin
        pat_num[j] = BlankPattern;
      end
    end
  end

  // digit pattern store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
    end else if (apply_cmd) begin
      if (cmd_q.op == OP_NUMBER) begin
        pat_q <= pat_num;
      end else begin
        for (int j = 0; j < DigitCount; j++) begin
          if (cmd_q.position == PosW'(j)) begin
            pat_q[j] <= cmd_q.pattern;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_bytes_q <= pack_bytes(pat_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_bytes_o = out_bytes_q;

endmodule

`default_nettype wire

[verif/lcd_decimal_digit_writer_unit_tb.sv]
// self-checking testbench for the lcd decimal digit writer unit
module lcd_decimal_digit_writer_unit_tb;
  import ldw_pkg::*;

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned SettleTicks = 64;
  localparam int unsigned HoldTicks   = 300;
  localparam int unsigned MaxReports  = 10;

  // one display command as the sender sees it
  typedef struct {
    op_e              op;
    logic [CharW-1:0] code;
    logic [PosW-1:0]  pos;
    logic [NumW-1:0]  value;
  } display_cmd_t;

  logic             clk_i;
  logic             rst_ni;
  logic             push;
  logic             full;
  logic             op_i;
  logic [CharW-1:0] char_code_i;
  logic [PosW-1:0]  position_i;
  logic [NumW-1:0]  number_i;
  logic             empty;
  logic             pop;
  logic [7:0]       row0_digits01_o, row0_digits23_o, row0_digits45_o;
  logic [7:0]       row1_digits01_o, row1_digits23_o, row1_digits45_o;
  logic [7:0]       row2_digits01_o, row2_digits23_o, row2_digits45_o;
  logic [7:0]       row3_digits01_o, row3_digits23_o, row3_digits45_o;

  // predictor state and the frames still owed by the block
  pattern_t    shown_glyphs [DigitCount];
  bytes_t      pending_frames [$];
  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned pop_stall_pct;
  bit          pop_hold;

  lcd_decimal_digit_writer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .op_i            (op_i),
    .char_code_i     (char_code_i),
    .position_i      (position_i),
    .number_i        (number_i),
    .empty           (empty),
    .pop             (pop),
    .row0_digits01_o (row0_digits01_o),
    .row0_digits23_o (row0_digits23_o),
    .row0_digits45_o (row0_digits45_o),
    .row1_digits01_o (row1_digits01_o),
    .row1_digits23_o (row1_digits23_o),
    .row1_digits45_o (row1_digits45_o),
    .row2_digits01_o (row2_digits01_o),
    .row2_digits23_o (row2_digits23_o),
    .row2_digits45_o (row2_digits45_o),
    .row3_digits01_o (row3_digits01_o),
    .row3_digits23_o (row3_digits23_o),
    .row3_digits45_o (row3_digits45_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // segment glyph of one decimal digit
  function automatic pattern_t glyph_of_digit(input int unsigned d);
    case (d)
      0: return 16'h1551;
      1: return 16'h2080;
      2: return 16'h1e11;
      3: return 16'h1b11;
      4: return 16'h0b50;
      5: return 16'h1b41;
      6: return 16'h1f41;
      7: return 16'h0111;
      8: return 16'h1f51;
      9: return 16'h0b51;
      default: return 16'h0000;
    endcase
  endfunction

  // apply one command to the predicted glyphs
  function automatic void update_glyphs(input display_cmd_t cmd);
    int unsigned decimals [10];
    int unsigned n;
    int unsigned v;
    if (cmd.op == OP_CHAR) begin
      if (cmd.pos < DigitCount) begin
        if (cmd.code >= 8'd48 && cmd.code <= 8'd57) begin
          shown_glyphs[cmd.pos] = glyph_of_digit(cmd.code - 8'd48);
        end else begin
          shown_glyphs[cmd.pos] = 16'h0000;
        end
      end
    end else begin
      // least significant decimal first, then shown most significant first
      v = cmd.value;
      n = 0;
      do begin
        decimals[n] = v % 10;
        v = v / 10;
        n++;
      end while (v != 0);
      for (int j = 0; j < DigitCount; j++) begin
        shown_glyphs[j] = (j < n) ? glyph_of_digit(decimals[n-1-j]) : 16'h0000;
      end
    end
  endfunction

  // pack the predicted glyphs into the twelve lcd register bytes
  function automatic bytes_t lcd_frame();
    bytes_t f;
    for (int r = 0; r < RowCount; r++) begin
      for (int p = 0; p < PairCount; p++) begin
        f[r*PairCount+p] = {shown_glyphs[2*p+1][4*r+:4], shown_glyphs[2*p][4*r+:4]};
      end
    end
    return f;
  endfunction

  function automatic string byte_name(input int k);
    return $sformatf("row%0d_digits%0d%0d", k / 3, 2 * (k % 3), 2 * (k % 3) + 1);
  endfunction

  // send one command, predicting its frame at the transfer
  task automatic send_cmd(input display_cmd_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push        = 1'b1;
    op_i        = cmd.op;
    char_code_i = cmd.code;
    position_i  = cmd.pos;
    number_i    = cmd.value;
    do @(posedge clk_i); while (full);
    update_glyphs(cmd);
    pending_frames.push_back(lcd_frame());
    @(negedge clk_i);
  endtask

  function automatic display_cmd_t char_cmd(input int code, input int pos);
    display_cmd_t c;
    c.op    = OP_CHAR;
    c.code  = CharW'(code);
    c.pos   = PosW'(pos);
    c.value = NumW'({$urandom()} >> 1);
    return c;
  endfunction

  function automatic display_cmd_t number_cmd(input int unsigned value);
    display_cmd_t c;
    c.op    = OP_NUMBER;
    c.code  = CharW'($urandom_range(255));
    c.pos   = PosW'($urandom_range(7));
    c.value = NumW'(value);
    return c;
  endfunction

  // random command, mostly digits and numbers of every decimal length
  function automatic display_cmd_t random_cmd();
    int unsigned len;
    int unsigned lo;
    int unsigned hi;
    if ($urandom_range(1) == 0) begin
      if ($urandom_range(9) < 7) begin
        return char_cmd($urandom_range(57, 48), $urandom_range(7));
      end
      return char_cmd($urandom_range(255), $urandom_range(7));
    end
    if ($urandom_range(9) < 2) begin
      return number_cmd({$urandom()} >> 1);
    end
    len = $urandom_range(10, 1);
    if (len == 10) begin
      return number_cmd($urandom_range(32'd2147483647, 32'd1000000000));
    end
    lo = 1;
    for (int i = 1; i < len; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (len == 1) lo = 0;
    return number_cmd($urandom_range(hi, lo));
  endfunction

  // receiver side: random stalls, or a long hold-off when asked
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      pop = !pop_hold && ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // compare each result transfer with the oldest predicted frame
  always @(posedge clk_i) begin : frame_check
    bytes_t seen;
    bytes_t want;
    if (rst_ni && pop && !empty) begin
      seen = {row3_digits45_o, row3_digits23_o, row3_digits01_o,
              row2_digits45_o, row2_digits23_o, row2_digits01_o,
              row1_digits45_o, row1_digits23_o, row1_digits01_o,
              row0_digits45_o, row0_digits23_o, row0_digits01_o};
      if (pending_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("error: result transfer with no frame predicted");
        end
      end else begin
        want = pending_frames.pop_front();
        if (seen != want) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            for (int k = 0; k < ByteCount; k++) begin
              if (seen[k] != want[k]) begin
                $display("error: %s expected %02h actual %02h",
                         byte_name(k), want[k], seen[k]);
              end
            end
          end
        end
      end
    end
  end

  // watchdog: cycles in a row without any transfer
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("lcd_decimal_digit_writer_unit regression: fail");
    $finish;
  end

  task automatic wait_drained();
    push = 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // every digit, out-of-range positions and non-digit codes
  task automatic test_char_writes();
    for (int d = 0; d < 10; d++) send_cmd(char_cmd(48 + d, d % 6));
    send_cmd(char_cmd(48, 6));
    send_cmd(char_cmd(255, 7));
    send_cmd(char_cmd(47, 0));
    send_cmd(char_cmd(58, 1));
    send_cmd(char_cmd(0, 2));
    send_cmd(char_cmd(255, 3));
  endtask

  // zero, short numbers, six digits exactly and truncated long numbers
  task automatic test_number_writes();
    send_cmd(number_cmd(0));
    send_cmd(number_cmd(7));
    send_cmd(number_cmd(42));
    send_cmd(number_cmd(100000));
    send_cmd(number_cmd(999999));
    send_cmd(number_cmd(1000000));
    send_cmd(number_cmd(123456789));
    send_cmd(number_cmd(32'd2147483647));
    send_cmd(number_cmd(10));
  endtask

  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) send_cmd(random_cmd());
    wait_drained();
  endtask

  // long receiver hold-off so the queue fills and full stalls the sender
  task automatic test_backpressure();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    fork
      begin
        pop_hold = 1'b1;
        repeat (HoldTicks) @(negedge clk_i);
        pop_hold = 1'b0;
      end
    join_none
    for (int i = 0; i < 30; i++) send_cmd(random_cmd());
    wait_drained();
  endtask

  initial begin
    rst_ni         = 1'b0;
    push           = 1'b0;
    op_i           = OP_CHAR;
    char_code_i    = '0;
    position_i     = '0;
    number_i       = '0;
    pop_hold       = 1'b0;
    send_idle_pct  = 0;
    pop_stall_pct  = 0;
    mismatch_count = 0;
    for (int i = 0; i < DigitCount; i++) shown_glyphs[i] = 16'h0000;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_char_writes();
    test_number_writes();
    wait_drained();
    test_random_traffic(175, 0, 0);
    test_random_traffic(175, 72, 0);
    test_random_traffic(175, 0, 72);
    test_random_traffic(175, 24, 24);
    test_backpressure();

    repeat (SettleTicks) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("lcd_decimal_digit_writer_unit regression: pass");
    end else begin
      $display("lcd_decimal_digit_writer_unit regression: fail");
    end
    $finish;
  end

endmodule
